// ===== rtl/trcf_pkg.sv =====
package trcf_pkg;

    // telnet command codes
    localparam logic [7:0] TEL_IAC  = 8'd255;
    localparam logic [7:0] TEL_DONT = 8'd254;
    localparam logic [7:0] TEL_DO   = 8'd253;
    localparam logic [7:0] TEL_WONT = 8'd252;
    localparam logic [7:0] TEL_WILL = 8'd251;
    localparam logic [7:0] TEL_SB   = 8'd250;
    localparam logic [7:0] TEL_SE   = 8'd240;

    // terminal control characters
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_BS  = 8'h08;

    // request operation codes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    // one parser step result
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
    } trcf_result_t;

endpackage

// ===== rtl/trcf_parser.sv =====
module trcf_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  operation,
    input  logic [7:0]            data_in,
    output trcf_pkg::trcf_result_t result
);
    import trcf_pkg::*;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_CMD    = 3'd1,
        MODE_OPT    = 3'd2,
        MODE_SB     = 3'd3,
        MODE_SB_IAC = 3'd4
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;
    logic  cr_seen_reg;
    logic  cr_seen_next;

    logic       line_en;
    logic [7:0] line_byte;

    // command sequence parser
    always_comb
    begin
        mode_next = mode_reg;
        line_en   = 1'b0;
        line_byte = data_in;
        unique case (mode_reg)
            MODE_CMD:
            begin
                if (data_in == TEL_IAC)
                begin
                    line_en   = 1'b1;
                    line_byte = TEL_IAC;
                    mode_next = MODE_NORMAL;
                end
                else if (data_in == TEL_WILL || data_in == TEL_WONT ||
                         data_in == TEL_DO   || data_in == TEL_DONT)
                begin
                    mode_next = MODE_OPT;
                end
                else if (data_in == TEL_SB)
                begin
                    mode_next = MODE_SB;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_OPT:
            begin
                mode_next = MODE_NORMAL;
            end
            MODE_SB:
            begin
                if (data_in == TEL_IAC)
                begin
                    mode_next = MODE_SB_IAC;
                end
            end
            MODE_SB_IAC:
            begin
                mode_next = (data_in == TEL_SE) ? MODE_NORMAL : MODE_SB;
            end
            default:
            begin
                if (data_in == TEL_IAC)
                begin
                    mode_next = MODE_CMD;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    line_en   = 1'b1;
                end
            end
        endcase
    end

    // line ending and control byte stage
    always_comb
    begin
        cr_seen_next = cr_seen_reg;
        result.emit  = 1'b0;
        result.data  = line_byte;
        if (line_en)
        begin
            if (line_byte == CH_CR)
            begin
                cr_seen_next = 1'b1;
                result.emit  = 1'b1;
            end
            else if (line_byte == CH_LF)
            begin
                if (cr_seen_reg)
                begin
                    cr_seen_next = 1'b0;
                end
                else
                begin
                    result.emit = 1'b1;
                    result.data = CH_CR;
                end
            end
            else if (line_byte == CH_NUL)
            begin
                cr_seen_next = 1'b0;
            end
            else
            begin
                cr_seen_next = 1'b0;
                result.emit  = 1'b1;
                if (line_byte == CH_DEL)
                begin
                    result.data = CH_BS;
                end
            end
        end
        if (operation == OP_RESET)
        begin
            result.emit = 1'b0;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            cr_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            if (operation == OP_RESET)
            begin
                mode_reg    <= MODE_NORMAL;
                cr_seen_reg <= 1'b0;
            end
            else
            begin
                mode_reg    <= mode_next;
                cr_seen_reg <= cr_seen_next;
            end
        end
    end

endmodule

// ===== rtl/telnet_rx_command_filter_unit.sv =====
// channel   | handshake                | payload
// ----------+--------------------------+-------------------------
// request   | byte_valid / byte_stall  | operation, data_in
// result    | clean_valid / clean_stall| out_byte
//
// one request per cycle sustained while byte_stall is low; each request is
// registered in the input register, is parsed there and lands in the result
// register, from which the cleaned byte is presented on out_byte.
// rst_n clears the valid flags and the parser state (normal mode, no cr).
// byte_stall rises only while both registers hold a request and clean_stall
// is high; requests that give no byte leave the input register without one.
module telnet_rx_command_filter_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic       operation,
    input  logic [7:0] data_in,
    output logic       clean_valid,
    input  logic       clean_stall,
    output logic [7:0] out_byte
);
    import trcf_pkg::*;

    logic       req_valid_reg;
    logic       req_op_reg;
    logic [7:0] req_data_reg;
    logic       res_valid_reg;
    logic [7:0] res_byte_reg;

    logic         advance;
    trcf_result_t step_result;

    // the input register moves on when the result register has room
    assign advance    = !res_valid_reg || !clean_stall;
    assign byte_stall = req_valid_reg && !advance;

    trcf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (req_valid_reg && advance),
        .operation (req_op_reg),
        .data_in   (req_data_reg),
        .result    (step_result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            req_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            req_op_reg   <= operation;
            req_data_reg <= data_in;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= req_valid_reg && step_result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && req_valid_reg && step_result.emit)
        begin
            res_byte_reg <= step_result.data;
        end
    end

    assign clean_valid = res_valid_reg;
    assign out_byte    = res_byte_reg;

endmodule
